### src/biou_pkg.sv
`default_nettype none
// ============================================================================
// biou_pkg: shared constants and types for the box overlap ratio unit
// Coordinate width default, ratio format, threshold reset and the tag that
// travels with every request through the divider pipeline.
// ============================================================================
package biou_pkg;

    // Default coordinate width (signed Q12.4 at 16 bits).
    localparam int COORD_WIDTH_DEF = 16;

    // Fraction bits of the ratio and total ratio width (one integer bit for 1.0).
    localparam int RATIO_BITS  = 16;
    localparam int RATIO_WIDTH = RATIO_BITS + 1;

    // Threshold register, Q1.16 with one integer bit, resets to 0.5.
    localparam int                     THRESH_WIDTH = RATIO_WIDTH;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(32768);

    // Control that accompanies a request through the pipeline.
    typedef struct packed {
        logic valid;  // stage holds a request
        logic hit;    // boxes overlap with positive width and height
    } t_biou_tag;

endpackage
`default_nettype wire

### src/biou_ifs.sv
`default_nettype none
// ============================================================================
// biou_ifs: request, result and configuration channels
// Valid/ready channels with source and sink modports.
// ============================================================================
interface biou_box_if #(
    parameter int COORD_WIDTH = biou_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_left;
    logic signed [COORD_WIDTH-1:0] a_top;
    logic signed [COORD_WIDTH-1:0] a_right;
    logic signed [COORD_WIDTH-1:0] a_bottom;
    logic signed [COORD_WIDTH-1:0] b_left;
    logic signed [COORD_WIDTH-1:0] b_top;
    logic signed [COORD_WIDTH-1:0] b_right;
    logic signed [COORD_WIDTH-1:0] b_bottom;

    modport source (
        output valid, a_left, a_top, a_right, a_bottom,
               b_left, b_top, b_right, b_bottom,
        input  ready
    );
    modport sink (
        input  valid, a_left, a_top, a_right, a_bottom,
               b_left, b_top, b_right, b_bottom,
        output ready
    );
endinterface

interface biou_iou_if;
    logic                                 valid;
    logic                                 ready;
    logic [biou_pkg::RATIO_WIDTH-1:0]     overlap_ratio;
    logic                                 above_threshold;

    modport source (output valid, overlap_ratio, above_threshold, input ready);
    modport sink   (input  valid, overlap_ratio, above_threshold, output ready);
endinterface

interface biou_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [biou_pkg::THRESH_WIDTH-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input  valid, data, output ready);
endinterface
`default_nettype wire

### src/box_iou_unit.sv
`default_nettype none
// ============================================================================
// box_iou_unit: intersection over union of two axis-aligned boxes
// Overlap ratio in unsigned Q1.16 plus a flag that compares it against a
// programmable threshold.
// ============================================================================
// A request runs through stages 1 to 3, the divider and the output register.
// Throughput: one request per cycle unless o_iou stalls; every stage is one
// register deep and the 17-bit quotient is produced one bit per divider stage.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets the match
// threshold to 0.5 (32768). No clearing pass is needed after reset.
module box_iou_unit #(
    parameter int COORD_WIDTH = biou_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    biou_box_if.sink   i_box,
    biou_cfg_if.sink   i_cfg,
    biou_iou_if.source o_iou
);
    import biou_pkg::*;

    // Products of two positive widths need 2W bits; the union can reach
    // one bit more, since area A plus area B minus the overlap is below 2^(2W+1).
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int UNI_WIDTH  = PROD_WIDTH + 1;
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;

    // ------------------------------------------------------------------
    // Flow control. The pipeline moves as one: it advances whenever the
    // output register is empty or its result is being taken this cycle.
    // No request is taken while reset is held.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_en;

    assign w_en        = !r_out_valid || o_iou.ready;
    assign i_box.ready = w_en && i_rst_n;

    // ------------------------------------------------------------------
    // Threshold register. Writes are taken whenever reset is released.
    // ------------------------------------------------------------------
    logic [THRESH_WIDTH-1:0] r_thresh;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg.valid) begin
            r_thresh <= i_cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: overlap edges and all six extents. Each extent is a
    // W+1-bit signed difference. When the overlap width and height are
    // both positive, each box's own right edge lies past its left edge
    // (and likewise vertically), so every extent then fits in W unsigned
    // bits and only those are kept.
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] w_in_l, w_in_r, w_in_t, w_in_b;
    logic signed [DIFF_WIDTH-1:0]  w_ov_w, w_ov_h, w_a_w, w_a_h, w_b_w, w_b_h;
    logic                          w_hit;

    always_comb begin
        w_in_l = (i_box.a_left  > i_box.b_left)  ? i_box.a_left  : i_box.b_left;
        w_in_t = (i_box.a_top   > i_box.b_top)   ? i_box.a_top   : i_box.b_top;
        w_in_r = (i_box.a_right < i_box.b_right) ? i_box.a_right : i_box.b_right;
        w_in_b = (i_box.a_bottom < i_box.b_bottom) ? i_box.a_bottom : i_box.b_bottom;

        w_ov_w = DIFF_WIDTH'(w_in_r) - DIFF_WIDTH'(w_in_l);
        w_ov_h = DIFF_WIDTH'(w_in_b) - DIFF_WIDTH'(w_in_t);
        w_a_w  = DIFF_WIDTH'(i_box.a_right)  - DIFF_WIDTH'(i_box.a_left);
        w_a_h  = DIFF_WIDTH'(i_box.a_bottom) - DIFF_WIDTH'(i_box.a_top);
        w_b_w  = DIFF_WIDTH'(i_box.b_right)  - DIFF_WIDTH'(i_box.b_left);
        w_b_h  = DIFF_WIDTH'(i_box.b_bottom) - DIFF_WIDTH'(i_box.b_top);

        w_hit  = (w_ov_w > 0) && (w_ov_h > 0);
    end

    t_biou_tag              r1_tag;
    logic [COORD_WIDTH-1:0] r1_ov_w, r1_ov_h, r1_a_w, r1_a_h, r1_b_w, r1_b_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
        end else if (w_en) begin
            r1_tag.valid <= i_box.valid;
            r1_tag.hit   <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ov_w <= w_ov_w[COORD_WIDTH-1:0];
            r1_ov_h <= w_ov_h[COORD_WIDTH-1:0];
            r1_a_w  <= w_a_w[COORD_WIDTH-1:0];
            r1_a_h  <= w_a_h[COORD_WIDTH-1:0];
            r1_b_w  <= w_b_w[COORD_WIDTH-1:0];
            r1_b_h  <= w_b_h[COORD_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three areas, one W by W multiplier each.
    // ------------------------------------------------------------------
    t_biou_tag             r2_tag;
    logic [PROD_WIDTH-1:0] r2_cross, r2_area_a, r2_area_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (w_en) begin
            r2_tag <= r1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cross  <= PROD_WIDTH'(r1_ov_w) * PROD_WIDTH'(r1_ov_h);
            r2_area_a <= PROD_WIDTH'(r1_a_w)  * PROD_WIDTH'(r1_a_h);
            r2_area_b <= PROD_WIDTH'(r1_b_w)  * PROD_WIDTH'(r1_b_h);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: union area. Exact at full width, never negative on a hit.
    // ------------------------------------------------------------------
    t_biou_tag            r3_tag;
    logic [UNI_WIDTH-1:0] r3_cross, r3_union;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
        end else if (w_en) begin
            r3_tag <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_cross <= UNI_WIDTH'(r2_cross);
            r3_union <= UNI_WIDTH'(r2_area_a) + UNI_WIDTH'(r2_area_b)
                      - UNI_WIDTH'(r2_cross);
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 20: restoring division, one quotient bit per stage.
    // On a miss the divider still runs on meaningless operands; the
    // result is forced to zero at the output.
    // ------------------------------------------------------------------
    t_biou_tag              w_div_tag;
    logic [RATIO_WIDTH-1:0] w_div_quo;

    biou_div #(
        .NUM_WIDTH (UNI_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (r3_tag),
        .i_num   (r3_cross),
        .i_den   (r3_union),
        .o_tag   (w_div_tag),
        .o_quo   (w_div_quo)
    );

    // ------------------------------------------------------------------
    // Stage 21: output register with the threshold compare. A threshold
    // of 65536 or above can never be exceeded, so the flag stays low.
    // ------------------------------------------------------------------
    logic [RATIO_WIDTH-1:0] w_ratio;
    logic [RATIO_WIDTH-1:0] r_ratio;
    logic                   r_above;

    assign w_ratio = w_div_tag.hit ? w_div_quo : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ratio <= w_ratio;
            r_above <= (w_ratio > r_thresh);
        end
    end

    assign o_iou.valid           = r_out_valid;
    assign o_iou.overlap_ratio   = r_ratio;
    assign o_iou.above_threshold = r_above;

endmodule
`default_nettype wire

### src/biou_div.sv
`default_nettype none
// ============================================================================
// biou_div: pipelined fractional divider
// Computes floor(num * 2^RATIO_BITS / den) for 0 < num <= den, one quotient
// bit per register stage, so a new division enters every cycle with i_en high.
// ============================================================================
module biou_div #(
    parameter int NUM_WIDTH = 2 * biou_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  biou_pkg::t_biou_tag               i_tag,
    input  logic [NUM_WIDTH-1:0]              i_num,
    input  logic [NUM_WIDTH-1:0]              i_den,
    output biou_pkg::t_biou_tag               o_tag,
    output logic [biou_pkg::RATIO_WIDTH-1:0]  o_quo
);
    import biou_pkg::*;

    localparam int STAGES = RATIO_BITS + 1;

    t_biou_tag              r_tag [STAGES];
    logic [RATIO_WIDTH-1:0] r_quo [STAGES];
    logic [NUM_WIDTH-1:0]   r_den [STAGES-1];
    logic [NUM_WIDTH-1:0]   r_rem [STAGES-1];

    // Stage zero settles the integer bit: it is one only when num equals den.
    logic                 n_bit0;
    logic [NUM_WIDTH-1:0] n_rem0;

    always_comb begin
        n_bit0 = (i_num >= i_den);
        n_rem0 = n_bit0 ? (i_num - i_den) : i_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo[0] <= RATIO_WIDTH'(n_bit0);
            r_rem[0] <= n_rem0;
            r_den[0] <= i_den;
        end
    end

    // Remaining stages each shift the partial remainder and try one subtract.
    for (genvar k = 1; k < STAGES; k++) begin : g_stage
        logic [NUM_WIDTH:0] n_shift;
        logic               n_bit;

        always_comb begin
            n_shift = {r_rem[k-1], 1'b0};
            n_bit   = (n_shift >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else if (i_en) begin
                r_tag[k] <= r_tag[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {r_quo[k-1][RATIO_WIDTH-2:0], n_bit};
            end
        end

        if (k < STAGES - 1) begin : g_rem
            logic [NUM_WIDTH:0] n_diff;

            assign n_diff = n_shift - {1'b0, r_den[k-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_bit ? n_diff[NUM_WIDTH-1:0] : n_shift[NUM_WIDTH-1:0];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_tag = r_tag[STAGES-1];
    assign o_quo = r_quo[STAGES-1];

endmodule
`default_nettype wire
